>>> src/shf_pkg.sv
// Shared types, constants and mixing functions for the SuperFastHash block.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package shf_pkg;

    localparam int HASH_W           = 32;
    localparam int LENGTH_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // Round to run on a queued word
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_FULL  = 3'd1,
        OP_TAIL1 = 3'd2,
        OP_TAIL2 = 3'd3,
        OP_TAIL3 = 3'd4
    } shf_op_t;

    typedef struct packed {
        shf_op_t op;
        logic    first;
        logic    last;
    } shf_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } shf_q_stat_t;

    typedef struct packed {
        logic mix_valid;
        logic mid_valid;
    } shf_bk_stat_t;

    function automatic logic [HASH_W-1:0] sext8(input logic [7:0] b);
        return {{(HASH_W-8){b[7]}}, b};
    endfunction

    function automatic logic [HASH_W-1:0] full_round(input logic [HASH_W-1:0] h_in,
                                                     input logic [HASH_W-1:0] w);
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] t;
        h = h_in + {16'd0, w[15:0]};
        t = ({16'd0, w[31:16]} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] tail_round(input logic [HASH_W-1:0] h_in,
                                                     input logic [HASH_W-1:0] w,
                                                     input shf_op_t         op);
        logic [HASH_W-1:0] h;
        h = h_in;
        case (op)
            OP_TAIL3:
            begin
                h = h + {16'd0, w[15:0]};
                h = h ^ (h << 16);
                h = h ^ (sext8(w[23:16]) << 18);
                h = h + (h >> 11);
            end
            OP_TAIL2:
            begin
                h = h + {16'd0, w[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            OP_TAIL1:
            begin
                h = h + sext8(w[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default:
            begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    // First half of the avalanche
    function automatic logic [HASH_W-1:0] aval_a(input logic [HASH_W-1:0] h_in);
        logic [HASH_W-1:0] h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        return h;
    endfunction

    // Second half of the avalanche
    function automatic logic [HASH_W-1:0] aval_b(input logic [HASH_W-1:0] h_in);
        logic [HASH_W-1:0] h;
        h = h_in + (h_in >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

`default_nettype wire

>>> src/shf_if.sv
// Valid/ready channel interfaces for message words in and hash words out.
// Depends on shf_pkg for the hash width and the default length width.
`default_nettype none

interface shf_in_if #(
    parameter int LENGTH_WIDTH = shf_pkg::LENGTH_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [31:0]             data_word;
    logic [2:0]              valid_bytes;
    logic                    first;
    logic                    last;
    logic [LENGTH_WIDTH-1:0] msg_length;

    modport source (output valid, data_word, valid_bytes, first, last, msg_length,
                    input ready);
    modport sink   (input valid, data_word, valid_bytes, first, last, msg_length,
                    output ready);
endinterface

interface shf_out_if;
    logic                        valid;
    logic                        ready;
    logic [shf_pkg::HASH_W-1:0]  hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

>>> src/superfast_hash_32.sv
// Path: a closing word passes the queue, the mix register and the two registered
//   avalanche stages (mid, hash). Throughput: one message word per cycle while the
//   queue has room; the round engine retires one queued word per cycle unless a
//   closing word waits for room. Reset: rst_n clears the framing flag, queue
//   pointers, running hash and all stage valid flags; no clearing pass is needed.
`default_nettype none

module superfast_hash_32 #(
    parameter int LENGTH_WIDTH = shf_pkg::LENGTH_WIDTH_DEF,
    parameter int QUEUE_DEPTH  = shf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    shf_in_if.sink    msg_in,
    shf_out_if.source hash_out
);
    import shf_pkg::*;

    // Front end to queue
    logic                    q_push;
    shf_ctrl_t               push_ctrl;
    logic [31:0]             push_word;
    logic [LENGTH_WIDTH-1:0] push_seed;

    // Queue to round engine
    logic                    q_pop;
    shf_ctrl_t               head_ctrl;
    logic [31:0]             head_word;
    logic [LENGTH_WIDTH-1:0] head_seed;
    shf_q_stat_t             q_stat;
    shf_bk_stat_t            bk_stat;

    // Front end: decide which words belong to a message and which round they run.
    // Words arriving outside a message without the first flag are dropped here.
    shf_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_in    (msg_in),
        .q_full    (q_stat.full),
        .push      (q_push),
        .push_ctrl (push_ctrl),
        .push_word (push_word),
        .push_seed (push_seed)
    );

    // Queue: lets the input keep flowing while the hash output is stalled, until it is full.
    shf_queue #(
        .LENGTH_WIDTH (LENGTH_WIDTH),
        .DEPTH        (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_ctrl (push_ctrl),
        .push_word (push_word),
        .push_seed (push_seed),
        .pop       (q_pop),
        .head_ctrl (head_ctrl),
        .head_word (head_word),
        .head_seed (head_seed),
        .stat      (q_stat)
    );

    // Round engine: seed on the first word, mix each word, avalanche on the last.
    shf_back #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_stat.empty),
        .head_ctrl (head_ctrl),
        .head_word (head_word),
        .head_seed (head_seed),
        .pop       (q_pop),
        .stat      (bk_stat),
        .hash_out  (hash_out)
    );

    // Never write a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("queue written while full");

    // Never read an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    // A mixed word advances into an empty avalanche stage on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
                     (bk_stat.mix_valid && !bk_stat.mid_valid) |=> bk_stat.mid_valid)
        else $error("mixed word failed to advance");

    // A stalled output must not let the avalanche stage behind it drop its word
    assert property (@(posedge clk) disable iff (!rst_n)
                     (bk_stat.mid_valid && hash_out.valid && !hash_out.ready)
                     |=> (bk_stat.mid_valid && hash_out.valid))
        else $error("avalanche word lost under output stall");

endmodule

`default_nettype wire

>>> src/shf_front.sv
// Front end: tracks message framing, drops stray words, classifies the round.
// Depends on shf_pkg and shf_in_if.
`default_nettype none

module shf_front #(
    parameter int LENGTH_WIDTH = shf_pkg::LENGTH_WIDTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    shf_in_if.sink                       msg_in,
    input  wire logic                    q_full,
    output logic                         push,
    output shf_pkg::shf_ctrl_t           push_ctrl,
    output logic [31:0]                  push_word,
    output logic [LENGTH_WIDTH-1:0]      push_seed
);
    import shf_pkg::*;

    logic    in_msg_reg;
    logic    in_msg_next;
    logic    accept;
    logic    keep;
    shf_op_t op;

    assign msg_in.ready = !q_full;
    assign accept       = msg_in.valid && msg_in.ready;
    assign keep         = msg_in.first || in_msg_reg;
    assign push         = accept && keep;

    always_comb
    begin
        if (!msg_in.last || (msg_in.valid_bytes inside {[3'd4:3'd7]}))
            op = OP_FULL;
        else if (msg_in.valid_bytes == 3'd3)
            op = OP_TAIL3;
        else if (msg_in.valid_bytes == 3'd2)
            op = OP_TAIL2;
        else if (msg_in.valid_bytes == 3'd1)
            op = OP_TAIL1;
        else
            op = OP_NONE;
    end

    assign push_ctrl = '{op: op, first: msg_in.first, last: msg_in.last};
    assign push_word = msg_in.data_word;
    assign push_seed = msg_in.msg_length;

    // open on first, close on last
    always_comb
    begin
        in_msg_next = in_msg_reg;
        if (push)
            in_msg_next = !msg_in.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_msg_reg <= 1'b0;
        else
            in_msg_reg <= in_msg_next;
    end

endmodule

`default_nettype wire

>>> src/shf_queue.sv
// Short word queue between front end and round engine.
// Depends on shf_pkg for the control and status structs and the parameter defaults.
`default_nettype none

module shf_queue #(
    parameter int LENGTH_WIDTH = shf_pkg::LENGTH_WIDTH_DEF,
    parameter int DEPTH        = shf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire shf_pkg::shf_ctrl_t      push_ctrl,
    input  wire logic [31:0]             push_word,
    input  wire logic [LENGTH_WIDTH-1:0] push_seed,
    input  wire logic                    pop,
    output shf_pkg::shf_ctrl_t           head_ctrl,
    output logic [31:0]                  head_word,
    output logic [LENGTH_WIDTH-1:0]      head_seed,
    output shf_pkg::shf_q_stat_t         stat
);
    import shf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    shf_ctrl_t               ctrl_mem [DEPTH];
    logic [31:0]             word_mem [DEPTH];
    logic [LENGTH_WIDTH-1:0] seed_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    assign head_ctrl = ctrl_mem[rd_ptr_reg];
    assign head_word = word_mem[rd_ptr_reg];
    assign head_seed = seed_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_mem[wr_ptr_reg] <= push_ctrl;
            word_mem[wr_ptr_reg] <= push_word;
            seed_mem[wr_ptr_reg] <= push_seed;
        end
    end

endmodule

`default_nettype wire

>>> src/shf_back.sv
// Round engine: running hash, mixing rounds and a two-stage avalanche.
// Depends on shf_pkg and shf_out_if.
`default_nettype none

module shf_back #(
    parameter int LENGTH_WIDTH = shf_pkg::LENGTH_WIDTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_empty,
    input  wire shf_pkg::shf_ctrl_t      head_ctrl,
    input  wire logic [31:0]             head_word,
    input  wire logic [LENGTH_WIDTH-1:0] head_seed,
    output logic                         pop,
    output shf_pkg::shf_bk_stat_t        stat,
    shf_out_if.source                    hash_out
);
    import shf_pkg::*;

    logic [HASH_W-1:0] run_reg, run_next;
    logic [HASH_W-1:0] mix_reg;
    logic [HASH_W-1:0] mid_reg;
    logic [HASH_W-1:0] hash_reg;
    logic              mix_valid_reg, mix_valid_next;
    logic              mid_valid_reg, mid_valid_next;
    logic              hash_valid_reg, hash_valid_next;
    logic              hash_free, mid_free, mix_free;
    logic [HASH_W-1:0] h_base;
    logic [HASH_W-1:0] h_round;

    assign hash_free = !hash_valid_reg || hash_out.ready;
    assign mid_free  = !mid_valid_reg || hash_free;
    assign mix_free  = !mix_valid_reg || mid_free;

    // a closing word needs room in the avalanche pipe
    assign pop = !q_empty && (!head_ctrl.last || mix_free);

    assign h_base  = head_ctrl.first ? HASH_W'(head_seed) : run_reg;
    assign h_round = (head_ctrl.op == OP_FULL) ? full_round(h_base, head_word)
                                               : tail_round(h_base, head_word, head_ctrl.op);

    always_comb
    begin
        run_next = run_reg;
        if (pop)
            run_next = head_ctrl.last ? '0 : h_round;
        mix_valid_next  = mix_free  ? (pop && head_ctrl.last) : mix_valid_reg;
        mid_valid_next  = mid_free  ? mix_valid_reg : mid_valid_reg;
        hash_valid_next = hash_free ? mid_valid_reg : hash_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg        <= '0;
            mix_valid_reg  <= 1'b0;
            mid_valid_reg  <= 1'b0;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg        <= run_next;
            mix_valid_reg  <= mix_valid_next;
            mid_valid_reg  <= mid_valid_next;
            hash_valid_reg <= hash_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mix_free)
            mix_reg <= h_round;
        if (mid_free)
            mid_reg <= aval_a(mix_reg);
        if (hash_free)
            hash_reg <= aval_b(mid_reg);
    end

    assign stat.mix_valid = mix_valid_reg;
    assign stat.mid_valid = mid_valid_reg;

    assign hash_out.valid      = hash_valid_reg;
    assign hash_out.hash_value = hash_reg;

endmodule

`default_nettype wire
